// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/cdoy_pkg.sv -----
`default_nettype none

package cdoy_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 9;
    localparam int MDAY_W  = 5;

    // Reciprocal of 25 scaled by 2**20, rounded down; the quotient it gives
    // is low by at most one, which a single compare and subtract corrects.
    localparam logic [15:0] RECIP_25   = 16'd41943;
    localparam int          RECIP_SHIFT = 20;
    localparam int          PROD_W      = YEAR_W + 16;
    localparam int          QUOT_W      = 10;

    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [DAY_W-1:0]   COMMON_YEAR_DAYS = 9'd365;
    localparam logic [DAY_W-1:0]   LEAP_YEAR_DAYS   = 9'd366;

    typedef struct packed {
        logic               req_type;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day_value;
    } cdoy_in_t;

    typedef struct packed {
        logic [DAY_W-1:0]   year_day;
        logic [MONTH_W-1:0] month_out;
        logic [MDAY_W-1:0]  day_out;
        logic               error;
    } cdoy_out_t;

    // Item plus its leap-year flag, passed from the leap unit to the converter.
    typedef struct packed {
        cdoy_in_t item;
        logic     leap;
    } cdoy_lp_t;

    // Length of month idx+1 (idx 0..11); zero for indexes that name no month.
    function automatic logic [MDAY_W-1:0] month_len(input logic leap,
                                                    input logic [MONTH_W-1:0] idx);
        logic [MDAY_W-1:0] len;
        case (idx)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the year before the first day of month idx+1 (idx 0..11).
    function automatic logic [DAY_W-1:0] cum_days(input logic leap,
                                                  input logic [MONTH_W-1:0] idx);
        logic [DAY_W-1:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && idx >= 4'd2 && idx <= 4'd11)
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/calendar_day_of_year_convert.sv -----
// Gregorian date converter with one valid/ready request channel and one
// valid/ready response channel, one response item for every request item.
// With req_type 0 an item carries year, month and day of month and the
// response gives the day of the year; with req_type 1 it carries year and
// day of year and the response gives month and day of month. Leap years
// follow the 4, 100 and 400 rule, and year 0 counts as a leap year. Any
// out-of-range input (month outside 1..12, day 0, day past the end of its
// month or of its year) sets error and zeroes the other fields, and a field
// that does not belong to the chosen direction reads as zero. The block is
// a four-stage pipeline: year / 25 by reciprocal multiply, leap test, range
// checks with the month search by parallel compares against the month start
// table, and the day of month subtraction into the output register. One
// item enters every cycle while the response side keeps taking items.
// When the response side stalls the pipeline fills up and then holds
// every item in place; bubbles close up first, so request ready drops only
// when all four stages hold an item.
`default_nettype none

module calendar_day_of_year_convert import cdoy_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire cdoy_in_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output cdoy_out_t     rsp
);

    // Item with its leap flag, between the leap unit and the converter.
    logic     lp_valid;
    logic     lp_ready;
    cdoy_lp_t lp;

    cdoy_leap u_leap (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .lp_valid  (lp_valid),
        .lp_ready  (lp_ready),
        .lp        (lp)
    );

    cdoy_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .lp_valid  (lp_valid),
        .lp_ready  (lp_ready),
        .lp        (lp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ----- hdl/cdoy_leap.sv -----
`default_nettype none

// Two-stage leap-year unit: stage one forms year / 25 by a reciprocal
// multiply, stage two corrects the remainder and applies the 4/100/400 rule.
module cdoy_leap import cdoy_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire cdoy_in_t req,
    output logic          lp_valid,
    input  wire logic     lp_ready,
    output cdoy_lp_t      lp
);

    logic                s1_valid_reg;
    cdoy_in_t            s1_item_reg;
    logic [QUOT_W-1:0]   s1_quot_reg;
    logic [PROD_W-1:0]   s1_prod;

    logic                s2_valid_reg;
    cdoy_lp_t            s2_data_reg;
    cdoy_lp_t            s2_data_next;

    logic                s1_ready;
    logic                s2_ready;

    logic [YEAR_W-1:0]   rem_wide;
    logic [5:0]          rem_raw;
    logic [5:0]          rem_fix;
    logic                by25;
    logic                div4;
    logic                div16;

    assign s2_ready  = !s2_valid_reg || lp_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req_ready = s1_ready;

    assign s1_prod = PROD_W'(req.year) * PROD_W'(RECIP_25);

    always_comb
    begin
        rem_wide = s1_item_reg.year - (YEAR_W'(s1_quot_reg) * YEAR_W'(5'd25));
        rem_raw  = rem_wide[5:0];
        if (rem_raw >= 6'd25)
        begin
            rem_fix = rem_raw - 6'd25;
        end
        else
        begin
            rem_fix = rem_raw;
        end
        by25  = (rem_fix == 6'd0);
        div4  = (s1_item_reg.year[1:0] == 2'd0);
        div16 = (s1_item_reg.year[3:0] == 4'd0);
        s2_data_next.item = s1_item_reg;
        s2_data_next.leap = (div4 && !by25) || (div16 && by25);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && s1_ready)
        begin
            s1_item_reg <= req;
            s1_quot_reg <= s1_prod[RECIP_SHIFT +: QUOT_W];
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign lp_valid = s2_valid_reg;
    assign lp       = s2_data_reg;

endmodule

`default_nettype wire

// ----- hdl/cdoy_conv.sv -----
`default_nettype none

// Two-stage converter: stage three checks ranges, sums the day of year and
// finds the month by parallel compares; stage four forms the day of month
// and holds the result.
module cdoy_conv import cdoy_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     lp_valid,
    output logic          lp_ready,
    input  wire cdoy_lp_t lp,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output cdoy_out_t     rsp
);

    logic                s3_valid_reg;
    logic                s3_mode_reg;
    logic                s3_err_reg;
    logic                s3_leap_reg;
    logic [DAY_W-1:0]    s3_yd_reg;
    logic [MONTH_W-1:0]  s3_idx_reg;
    logic [DAY_W-1:0]    s3_dval_reg;

    logic                s3_err_next;
    logic [DAY_W-1:0]    s3_yd_next;
    logic [MONTH_W-1:0]  s3_idx_next;

    logic                rsp_valid_reg;
    cdoy_out_t           rsp_reg;
    cdoy_out_t           rsp_next;

    logic                s3_ready;
    logic                s4_ready;

    logic [MONTH_W-1:0]  mon_m1;
    logic                ok_fwd;
    logic                ok_rev;
    logic [DAY_W-1:0]    year_len;
    logic [DAY_W-1:0]    day_diff;

    assign s4_ready = !rsp_valid_reg || rsp_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign lp_ready = s3_ready;

    always_comb
    begin
        mon_m1   = lp.item.month - 4'd1;
        year_len = lp.leap ? LEAP_YEAR_DAYS : COMMON_YEAR_DAYS;
        ok_fwd   = (lp.item.month != 4'd0) && (lp.item.month <= MONTHS_PER_YEAR) &&
                   (lp.item.day_value != 9'd0) &&
                   (lp.item.day_value <= DAY_W'(month_len(lp.leap, mon_m1)));
        ok_rev   = (lp.item.day_value != 9'd0) && (lp.item.day_value <= year_len);
        s3_err_next = lp.item.req_type ? !ok_rev : !ok_fwd;
        s3_yd_next  = cum_days(lp.leap, mon_m1) + lp.item.day_value;
        // The month start table rises, so the number of month starts the
        // day has passed is the zero-based month index.
        s3_idx_next = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (lp.item.day_value > cum_days(lp.leap, MONTH_W'(k)))
            begin
                s3_idx_next = s3_idx_next + 4'd1;
            end
        end
    end

    always_comb
    begin
        day_diff = s3_dval_reg - cum_days(s3_leap_reg, s3_idx_reg);
        rsp_next = '0;
        if (!s3_err_reg)
        begin
            if (s3_mode_reg)
            begin
                rsp_next.month_out = s3_idx_reg + 4'd1;
                rsp_next.day_out   = day_diff[MDAY_W-1:0];
            end
            else
            begin
                rsp_next.year_day = s3_yd_reg;
            end
        end
        else
        begin
            rsp_next.error = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
            begin
                s3_valid_reg <= lp_valid;
            end
            if (s4_ready)
            begin
                rsp_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lp_valid && s3_ready)
        begin
            s3_mode_reg <= lp.item.req_type;
            s3_err_reg  <= s3_err_next;
            s3_leap_reg <= lp.leap;
            s3_yd_reg   <= s3_yd_next;
            s3_idx_reg  <= s3_idx_next;
            s3_dval_reg <= lp.item.day_value;
        end
        if (s3_valid_reg && s4_ready)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- hdl/cdoy_check.sv -----
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the converter's response channel.
module cdoy_check import cdoy_pkg::*; (
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      rsp_valid,
    input wire logic      rsp_ready,
    input wire cdoy_out_t rsp
);

    // Shapes a response may take: all zero on error, only the day of year
    // in one direction, only month and day of month in the other.
    logic rsp_zero;
    logic fwd_shape;
    logic rev_shape;

    assign rsp_zero  = (rsp.year_day == 9'd0) && (rsp.month_out == 4'd0) &&
                       (rsp.day_out == 5'd0);
    assign fwd_shape = (rsp.year_day != 9'd0) && (rsp.month_out == 4'd0) &&
                       (rsp.day_out == 5'd0);
    assign rev_shape = (rsp.year_day == 9'd0) && (rsp.month_out != 4'd0) &&
                       (rsp.month_out <= MONTHS_PER_YEAR) && (rsp.day_out != 5'd0);

    `ASSERT_CLK(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "response changed while stalled")
    `ASSERT_CLK(a_err_zero, clk, rst_n, rsp_valid && rsp.error |-> rsp_zero, "error item carries nonzero fields")
    `ASSERT_CLK(a_one_dir, clk, rst_n, rsp_valid && !rsp.error |-> fwd_shape || rev_shape, "good item mixes directions")
    `ASSERT_CLK(a_yd_range, clk, rst_n, rsp_valid |-> rsp.year_day <= LEAP_YEAR_DAYS, "day of year above 366")

endmodule

bind calendar_day_of_year_convert cdoy_check u_cdoy_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import cdoy_pkg::*;

    // Direction codes carried in req_type.
    localparam logic TO_YEAR_DAY  = 1'b0;
    localparam logic TO_MONTH_DAY = 1'b1;

    // Random items after the directed ones, and how many items at the end
    // of the run go through with neither side idling.
    localparam int RANDOM_ITEMS = 1180;
    localparam int QUIET_TAIL   = 150;

    // The slowest correct run is about 1200 items, each meeting the longest
    // idle gap on the request side and on the response side plus the pipeline.
    // The limit leaves ample margin on top of that.
    localparam int CYCLE_LIMIT = 200000;

    // The long response stall starts once this many items have gone in.
    localparam int STALL_AT_ITEM = 300;
    localparam int STALL_CYCLES  = 60;

    logic      clk = 1'b0;
    logic      rst_n = 1'b1;
    logic      req_valid = 1'b0;
    logic      req_ready;
    cdoy_in_t  req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    cdoy_out_t rsp;

    // Items waiting to be offered, and the results they should produce,
    // oldest first.
    cdoy_in_t  pending_dates[$];
    cdoy_out_t expected_dates[$];

    int month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    int total_items = 0;
    int items_sent = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int hold_left = 0;
    bit long_stall_done = 1'b0;

    calendar_day_of_year_convert DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    // Gregorian leap rule: every fourth year, except centuries that are not
    // a multiple of 400. Year 0 comes out as a leap year.
    function automatic bit is_leap(input logic [YEAR_W-1:0] y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Length of month m (1..12) in a common or leap year.
    function automatic int days_in(input bit leap, input int m);
        return month_days[m - 1] + ((leap && m == 2) ? 1 : 0);
    endfunction

    // Expected result for one date item. Any field that does not belong to
    // the chosen direction, and every field on error, stays zero.
    function automatic cdoy_out_t convert_date(input cdoy_in_t d);
        cdoy_out_t r;
        bit        leap;
        int        days;
        int        m;
        r = '0;
        leap = is_leap(d.year);
        if (d.req_type == TO_YEAR_DAY)
        begin
            if (d.month < 1 || d.month > MONTHS_PER_YEAR || d.day_value < 1 ||
                int'(d.day_value) > days_in(leap, int'(d.month)))
            begin
                r.error = 1'b1;
            end
            else
            begin
                days = int'(d.day_value);
                for (m = 1; m < int'(d.month); m++)
                begin
                    days += days_in(leap, m);
                end
                r.year_day = days[DAY_W-1:0];
            end
        end
        else
        begin
            if (d.day_value < 1 || int'(d.day_value) > int'(COMMON_YEAR_DAYS) + int'(leap))
            begin
                r.error = 1'b1;
            end
            else
            begin
                // Walk the months until the remainder fits; December takes
                // whatever is left.
                days = int'(d.day_value);
                m = 1;
                while (m < 12 && days > days_in(leap, m))
                begin
                    days -= days_in(leap, m);
                    m++;
                end
                r.month_out = m[MONTH_W-1:0];
                r.day_out = days[MDAY_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic add_date(input logic dir, input int y, input int m, input int dv);
        cdoy_in_t d;
        d.req_type = dir;
        d.year = y[YEAR_W-1:0];
        d.month = m[MONTH_W-1:0];
        d.day_value = dv[DAY_W-1:0];
        pending_dates.push_back(d);
    endtask

    // Stimulus and end of run.
    initial
    begin
        cdoy_in_t    d;
        bit          leap;
        int          n;
        int          len;
        logic [31:0] raw;

        // A real falling edge on reset, so the asynchronous reset takes hold.
        #1 rst_n = 1'b0;

        // Directed part: month and day limits in both directions, the leap
        // rule at its edges, and the widest field values.
        add_date(TO_YEAR_DAY, 2023, 0, 10);          // month zero
        add_date(TO_YEAR_DAY, 2023, 13, 10);         // month just past December
        add_date(TO_YEAR_DAY, 2023, 15, 10);         // largest month code
        add_date(TO_YEAR_DAY, 2023, 5, 0);           // day zero
        add_date(TO_YEAR_DAY, 2023, 4, 31);          // past the end of April
        add_date(TO_YEAR_DAY, 2024, 2, 29);          // leap day in a leap year
        add_date(TO_YEAR_DAY, 2023, 2, 29);          // leap day in a common year
        add_date(TO_YEAR_DAY, 1900, 2, 29);          // century, not a leap year
        add_date(TO_YEAR_DAY, 2000, 2, 29);          // multiple of 400
        add_date(TO_YEAR_DAY, 0, 2, 29);             // year zero counts as leap
        add_date(TO_YEAR_DAY, 2024, 12, 31);         // day 366
        add_date(TO_YEAR_DAY, 16383, 1, 1);          // largest year, first day
        add_date(TO_YEAR_DAY, 16383, 12, 511);       // largest day code
        add_date(TO_MONTH_DAY, 2023, 0, 0);          // day of year zero
        add_date(TO_MONTH_DAY, 2023, 15, 365);       // last day, month field junk
        add_date(TO_MONTH_DAY, 2023, 0, 366);        // day 366 in a common year
        add_date(TO_MONTH_DAY, 2024, 0, 366);        // day 366 in a leap year
        add_date(TO_MONTH_DAY, 2024, 0, 60);         // leap day by day of year
        add_date(TO_MONTH_DAY, 2023, 0, 60);         // March 1 in a common year
        add_date(TO_MONTH_DAY, 0, 0, 511);           // largest day code
        add_date(TO_MONTH_DAY, 16383, 9, 1);         // largest year, first day
        add_date(TO_MONTH_DAY, 1900, 0, 366);        // century year is common

        // Random part: mostly well-formed dates with the year biased toward
        // the leap rule's boundaries, plus raw noise over every field bit.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                raw = $urandom;
                d = raw[$bits(cdoy_in_t)-1:0];
            end
            else
            begin
                d.req_type = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 3))
                    0: d.year = YEAR_W'($urandom);
                    1: d.year = YEAR_W'(400 * $urandom_range(0, 40));
                    2: d.year = YEAR_W'(100 * $urandom_range(0, 163));
                    default: d.year = YEAR_W'(4 * $urandom_range(0, 4095));
                endcase
                leap = is_leap(d.year);
                if (d.req_type == TO_YEAR_DAY)
                begin
                    d.month = MONTH_W'($urandom_range(1, 12));
                    len = days_in(leap, int'(d.month));
                    // Now and then step one day past the end of the month.
                    d.day_value = ($urandom_range(0, 9) == 0) ? DAY_W'(len + 1)
                                                              : DAY_W'($urandom_range(1, len));
                end
                else
                begin
                    d.month = MONTH_W'($urandom);
                    d.day_value = DAY_W'($urandom_range(1, 366));
                end
            end
            pending_dates.push_back(d);
        end
        total_items = pending_dates.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (items_sent == total_items);
        wait (expected_dates.size() == 0);
        // Let any stray result past the pipeline depth show up.
        repeat (8) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("** calendar_day_of_year_convert: PASSED **");
        end
        else
        begin
            $display("** calendar_day_of_year_convert: FAILED **");
        end
        $finish;
    end

    // Request driver. The expectation for an item is recorded at the edge
    // where it is accepted; the next item (or an idle gap) is chosen only
    // when the channel is free, so valid holds steady until acceptance.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                expected_dates.push_back(convert_date(req));
                items_sent++;
            end
            if (!req_valid || req_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (pending_dates.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                begin
                    // This edge is the first idle cycle of the burst.
                    send_gap = $urandom_range(1, 5) - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_dates.size() > 0)
                begin
                    req <= pending_dates.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Response back-pressure. Short random stalls, one long stall partway
    // through that lets the pipeline fill and push back on the request side,
    // and none at all near the end of the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!long_stall_done && items_sent >= STALL_AT_ITEM)
            begin
                long_stall_done = 1'b1;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (items_sent < total_items - QUIET_TAIL && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(1, 5) - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Response monitor. Each accepted result is checked against the oldest
    // outstanding expectation, field by field.
    always @(posedge clk)
    begin
        cdoy_out_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_dates.size() == 0)
            begin
                $error("unexpected result item: %p", rsp);
                mismatches++;
            end
            else
            begin
                want = expected_dates.pop_front();
                if (rsp.year_day !== want.year_day)
                begin
                    $error("year_day: expected %0d, got %0d", want.year_day, rsp.year_day);
                    mismatches++;
                end
                if (rsp.month_out !== want.month_out)
                begin
                    $error("month_out: expected %0d, got %0d", want.month_out,
                           rsp.month_out);
                    mismatches++;
                end
                if (rsp.day_out !== want.day_out)
                begin
                    $error("day_out: expected %0d, got %0d", want.day_out, rsp.day_out);
                    mismatches++;
                end
                if (rsp.error !== want.error)
                begin
                    $error("error: expected %0b, got %0b", want.error, rsp.error);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** calendar_day_of_year_convert: FAILED **");
            $finish;
        end
    end

endmodule
